@@ hdl/psc_pkg.sv @@
// Package for the pad-space string comparator: shared types, order codes
// and the ASCII case-fold helper. No dependencies.
`default_nettype none
package psc_pkg;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  localparam logic signed [1:0] ORD_LESS = 2'sb11;
  localparam logic signed [1:0] ORD_EQUAL = 2'sb00;
  localparam logic signed [1:0] ORD_GREATER = 2'sb01;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  localparam logic REG_TRIM = 1'b0;
  localparam logic REG_MATCH_CASE = 1'b1;

  typedef struct packed {
    logic trim;
    logic match_case;
  } cfg_t;

  // One classified position.
  typedef struct packed {
    logic left_present;
    logic right_present;
    logic left_keep;
    logic right_keep;
    logic mismatch;
    logic left_greater;
    logic last;
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } fifo_stat_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic match_case);
    logic [7:0] res;
    res = b;
    if (!match_case && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      res = b - CHAR_UPPER_A + CHAR_LOWER_A;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ hdl/psc_front.sv @@
// Front stage: classifies one byte pair into a position record.
// Depends on psc_pkg.
`default_nettype none
module psc_front (
  input  wire logic [7:0]      left_char,
  input  wire logic            left_present,
  input  wire logic [7:0]      right_char,
  input  wire logic            right_present,
  input  wire logic            last_position,
  input  wire psc_pkg::cfg_t   cfg,
  output psc_pkg::item_t       item
);

  logic [7:0] fold_l;
  logic [7:0] fold_r;

  always_comb begin
    fold_l = psc_pkg::fold_byte(left_char, cfg.match_case);
    fold_r = psc_pkg::fold_byte(right_char, cfg.match_case);
    item.left_present  = left_present;
    item.right_present = right_present;
    // drop trailing-space candidates from the kept length when trimming
    item.left_keep  = left_present && !(cfg.trim && left_char == psc_pkg::CHAR_SPACE);
    item.right_keep = right_present && !(cfg.trim && right_char == psc_pkg::CHAR_SPACE);
    item.mismatch     = left_present && right_present && (fold_l != fold_r);
    item.left_greater = fold_l > fold_r;
    item.last         = last_position;
  end

endmodule
`default_nettype wire

@@ hdl/psc_fifo.sv @@
// Short queue of position records between front and back.
// Depends on psc_pkg.
`default_nettype none
module psc_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire psc_pkg::item_t       push_item,
  input  wire logic                 pop,
  output psc_pkg::item_t            pop_item,
  output psc_pkg::fifo_stat_t       stat
);

  psc_pkg::item_t                     mem_r [psc_pkg::FIFO_DEPTH];
  logic [psc_pkg::FIFO_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [psc_pkg::FIFO_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [psc_pkg::FIFO_PTR_W:0]       count_r, count_nxt;
  logic                               do_push;
  logic                               do_pop;

  always_comb begin
    stat.valid = count_r != '0;
    stat.full  = count_r == (psc_pkg::FIFO_PTR_W+1)'(psc_pkg::FIFO_DEPTH);
    do_push    = push && !stat.full;
    do_pop     = pop && stat.valid;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
    pop_item = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

@@ hdl/psc_back.sv @@
// Back stage: position and length counters, first-mismatch record and the
// registered result. Depends on psc_pkg.
`default_nettype none
module psc_back #(
  parameter int MAX_LENGTH = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire psc_pkg::fifo_stat_t  fifo_stat,
  input  wire psc_pkg::item_t       item,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [1:0]         out_order,
  output logic                      out_too_long
);

  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam logic [CNT_W-1:0] POS_MAX = CNT_W'(MAX_LENGTH);

  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   lkeep_r, lkeep_nxt;
  logic [CNT_W-1:0]   rkeep_r, rkeep_nxt;
  logic [CNT_W-1:0]   mpos_r, mpos_nxt;
  logic               seen_r, seen_nxt;
  logic               lgt_r, lgt_nxt;
  logic               ovf_r, ovf_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic signed [1:0]  order_r, order_nxt;
  logic               toolong_r, toolong_nxt;
  logic [CNT_W-1:0]   pos_inc;

  always_comb begin
    pop         = fifo_stat.valid && (!ovalid_r || out_ready);
    pos_inc     = pos_r + 1'b1;
    pos_nxt     = pos_r;
    lkeep_nxt   = lkeep_r;
    rkeep_nxt   = rkeep_r;
    mpos_nxt    = mpos_r;
    seen_nxt    = seen_r;
    lgt_nxt     = lgt_r;
    ovf_nxt     = ovf_r;
    order_nxt   = order_r;
    toolong_nxt = toolong_r;
    ovalid_nxt  = ovalid_r && !out_ready;
    if (pop) begin
      if (pos_r == POS_MAX) begin
        // saturated: drop bytes, flag overflow
        ovf_nxt = ovf_r || item.left_present || item.right_present;
      end else begin
        if (item.left_keep) begin
          lkeep_nxt = pos_inc;
        end
        if (item.right_keep) begin
          rkeep_nxt = pos_inc;
        end
        if (!seen_r && item.mismatch) begin
          seen_nxt = 1'b1;
          mpos_nxt = pos_r;
          lgt_nxt  = item.left_greater;
        end
        pos_nxt = pos_inc;
      end
      if (item.last) begin
        if (seen_nxt && mpos_nxt < lkeep_nxt && mpos_nxt < rkeep_nxt) begin
          order_nxt = lgt_nxt ? psc_pkg::ORD_GREATER : psc_pkg::ORD_LESS;
        end else if (lkeep_nxt > rkeep_nxt) begin
          order_nxt = psc_pkg::ORD_GREATER;
        end else if (lkeep_nxt < rkeep_nxt) begin
          order_nxt = psc_pkg::ORD_LESS;
        end else begin
          order_nxt = psc_pkg::ORD_EQUAL;
        end
        toolong_nxt = ovf_nxt;
        ovalid_nxt  = 1'b1;
        pos_nxt     = '0;
        lkeep_nxt   = '0;
        rkeep_nxt   = '0;
        seen_nxt    = 1'b0;
        ovf_nxt     = 1'b0;
      end
    end
    out_valid    = ovalid_r;
    out_order    = order_r;
    out_too_long = toolong_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      lkeep_r  <= '0;
      rkeep_r  <= '0;
      mpos_r   <= '0;
      seen_r   <= 1'b0;
      lgt_r    <= 1'b0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      lkeep_r  <= lkeep_nxt;
      rkeep_r  <= rkeep_nxt;
      mpos_r   <= mpos_nxt;
      seen_r   <= seen_nxt;
      lgt_r    <= lgt_nxt;
      ovf_r    <= ovf_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    order_r   <= order_nxt;
    toolong_r <= toolong_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/pad_space_string_compare.sv @@
// Top level of the pad-space string comparator: APB register file, front
// classifier, record queue and back counters. Depends on psc_pkg.
//
// Two byte strings stream in side by side, one position per transfer, each
// with a present flag; in_tlast marks the final position of the pair, and
// one result transfer follows it: order -1 (left first), 0 (equal) or 1
// (right first), plus too_long when a present byte came at or beyond
// MAX_LENGTH positions. With trim_trailing_spaces set, trailing spaces do
// not count toward a string's length; with match_case clear, ASCII A-Z
// compare as a-z. The block takes one position per cycle while the queue
// has room; the back stage updates its counters for each record it pops,
// and out_tvalid rises once the last position has passed through it. A
// four-entry queue parts the input side from the counters, so a stalled
// result holds only the back stage while the front keeps taking positions
// until the queue fills. Registers: trim_trailing_spaces at 0x0,
// match_case at 0x4 (bit 0 of the data; only paddr[2] selects).
`default_nettype none
module pad_space_string_compare #(
  parameter int MAX_LENGTH = 65536
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata: left_char[7:0], left_present[8], right_char[16:9],
  // right_present[17], zero[23:18]
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [23:0]  in_tdata,
  input  wire logic         in_tlast,
  // out_tdata: order[1:0] (signed), too_long[2], zero[7:3]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [7:0]        out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic                 trim_r, trim_nxt;
  logic                 mcase_r, mcase_nxt;
  logic                 cfg_wr;
  psc_pkg::cfg_t        cfg;
  psc_pkg::item_t       front_item;
  psc_pkg::item_t       back_item;
  psc_pkg::fifo_stat_t  fifo_stat;
  logic                 fifo_pop;
  logic signed [1:0]    res_order;
  logic                 res_too_long;

  // APB register file; write on the access phase
  always_comb begin
    cfg_pready = 1'b1;
    cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
    trim_nxt   = trim_r;
    mcase_nxt  = mcase_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        psc_pkg::REG_TRIM:       trim_nxt = cfg_pwdata[0];
        psc_pkg::REG_MATCH_CASE: mcase_nxt = cfg_pwdata[0];
        default: ;
      endcase
    end
    case (cfg_paddr[2])
      psc_pkg::REG_TRIM:       cfg_prdata = {31'b0, trim_r};
      psc_pkg::REG_MATCH_CASE: cfg_prdata = {31'b0, mcase_r};
      default:                 cfg_prdata = '0;
    endcase
    cfg.trim       = trim_r;
    cfg.match_case = mcase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r  <= 1'b0;
      mcase_r <= 1'b1;
    end else begin
      trim_r  <= trim_nxt;
      mcase_r <= mcase_nxt;
    end
  end

  psc_front u_front (
    .left_char     (in_tdata[7:0]),
    .left_present  (in_tdata[8]),
    .right_char    (in_tdata[16:9]),
    .right_present (in_tdata[17]),
    .last_position (in_tlast),
    .cfg           (cfg),
    .item          (front_item)
  );

  // hold input while the queue is full
  assign in_tready = !fifo_stat.full;

  psc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_item (front_item),
    .pop       (fifo_pop),
    .pop_item  (back_item),
    .stat      (fifo_stat)
  );

  psc_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .fifo_stat    (fifo_stat),
    .item         (back_item),
    .pop          (fifo_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_order    (res_order),
    .out_too_long (res_too_long)
  );

  assign out_tdata = {5'b0, res_too_long, res_order};

`ifndef SYNTHESIS
  // order never takes the unused code -2
  a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'b10)
    else $error("order code out of range");

  // a result only appears when a queued record was consumed
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(fifo_stat.valid) && !$past(out_tvalid) |-> !out_tvalid)
    else $error("result without a queued record");

  // the back stage only consumes when the queue holds a record
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> fifo_stat.valid)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire
